>>> rtl/olmss_pkg.sv
// ---------------------------------------------------------------------------
// olmss_pkg
// Stage codes, register indexes and register reset values for the
// open-loop motor start sequencer.
// ---------------------------------------------------------------------------
package olmss_pkg;

    typedef enum logic [1:0] {
        STAGE_IDLE  = 2'd0,
        STAGE_ALIGN = 2'd1,
        STAGE_RAMP  = 2'd2,
        STAGE_HOLD  = 2'd3
    } stage_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IDLE_END      = 3'd0;
    localparam cfg_index_t REG_ALIGN_END     = 3'd1;
    localparam cfg_index_t REG_RAMP_END      = 3'd2;
    localparam cfg_index_t REG_ALIGN_CURRENT = 3'd3;
    localparam cfg_index_t REG_RUN_CURRENT   = 3'd4;
    localparam cfg_index_t REG_RAMP_STEP     = 3'd5;
    localparam cfg_index_t REG_HOLD_STEP     = 3'd6;

    localparam logic [15:0] IDLE_END_RST      = 16'd5000;
    localparam logic [15:0] ALIGN_END_RST     = 16'd10000;
    localparam logic [15:0] RAMP_END_RST      = 16'd45000;
    localparam logic [14:0] ALIGN_CURRENT_RST = 15'd26214;
    localparam logic [14:0] RUN_CURRENT_RST   = 15'd9830;
    localparam logic [23:0] RAMP_STEP_RST     = 24'd182;
    localparam logic [31:0] HOLD_STEP_RST     = 32'd5468522;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

endpackage

>>> rtl/open_loop_motor_startup_sequencer_unit.sv
// ---------------------------------------------------------------------------
// open_loop_motor_startup_sequencer_unit
// Current-forced open-loop motor start: idle, align, speed ramp and hold.
// ---------------------------------------------------------------------------
// Usage:
//   Each input item on in_valid/in_ready is one control tick; restart set
//   clears the tick counter, speed and phase before the tick is evaluated.
//   Each tick yields one result item on out_valid/out_ready carrying
//   iq_cmd (Q0.15), angle (upper 16 bits of the phase) and stage.
//   The result is in the output register in the cycle after the
//   item is taken. Throughput: one item per cycle, set by the single
//   output register; the state update is a few adds done in the same cycle.
//   A stalled receiver holds the result; in_ready drops only while the
//   output register is full and not being emptied.
//   Reset clears counter, speed, phase and the output valid flag and loads
//   the default register values. Registers are written through cfg_wr_en/
//   cfg_index/cfg_wdata, one per cycle, by the user only while no item is
//   in flight (not enforced by the block); indexes beyond the list are ignored.
// ---------------------------------------------------------------------------
module open_loop_motor_startup_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [14:0]                         iq_cmd,
    output logic [15:0]                         angle,
    output logic [1:0]                          stage,
    input  logic                                cfg_wr_en,
    input  logic [olmss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [olmss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [15:0] idle_end_reg;
    logic [15:0] align_end_reg;
    logic [15:0] ramp_end_reg;
    logic [14:0] align_current_reg;
    logic [14:0] run_current_reg;
    logic [23:0] ramp_step_reg;
    logic [31:0] hold_step_reg;

    logic [15:0] tick_count_reg;
    logic [31:0] ramp_speed_reg;
    logic [31:0] phase_acc_reg;

    logic              out_valid_reg;
    logic [14:0]       iq_cmd_reg;
    logic [15:0]       angle_reg;
    olmss_pkg::stage_t stage_reg;

    logic              in_fire;
    logic [15:0]       tick_cur;
    logic [31:0]       speed_cur;
    logic [31:0]       phase_cur;
    logic [32:0]       speed_sum;
    logic [31:0]       speed_ramp;
    logic [31:0]       phase_ramp;
    logic [31:0]       phase_hold;

    logic [15:0]       tick_count_next;
    logic [31:0]       ramp_speed_next;
    logic [31:0]       phase_acc_next;
    logic [14:0]       iq_cmd_next;
    logic [15:0]       angle_next;
    olmss_pkg::stage_t stage_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign iq_cmd    = iq_cmd_reg;
    assign angle     = angle_reg;
    assign stage     = stage_reg;

    assign tick_cur  = restart ? 16'd0 : tick_count_reg;
    assign speed_cur = restart ? 32'd0 : ramp_speed_reg;
    assign phase_cur = restart ? 32'd0 : phase_acc_reg;

    // saturating speed; on saturation the phase gains 0xFFFFFFFF, i.e. minus one
    assign speed_sum  = {1'b0, speed_cur} + {9'd0, ramp_step_reg};
    assign speed_ramp = speed_sum[32] ? 32'hFFFF_FFFF : speed_sum[31:0];
    assign phase_ramp = speed_sum[32] ? (phase_cur - 32'd1)
                                      : (phase_cur + speed_cur + {8'd0, ramp_step_reg});
    assign phase_hold = phase_cur + hold_step_reg;

    always_comb
    begin
        ramp_speed_next = speed_cur;
        phase_acc_next  = phase_cur;
        iq_cmd_next     = 15'd0;
        angle_next      = 16'd0;
        if (tick_cur < idle_end_reg)
        begin
            stage_next = olmss_pkg::STAGE_IDLE;
        end
        else if (tick_cur < align_end_reg)
        begin
            stage_next  = olmss_pkg::STAGE_ALIGN;
            iq_cmd_next = align_current_reg;
        end
        else if (tick_cur < ramp_end_reg)
        begin
            stage_next      = olmss_pkg::STAGE_RAMP;
            iq_cmd_next     = run_current_reg;
            ramp_speed_next = speed_ramp;
            phase_acc_next  = phase_ramp;
            angle_next      = phase_ramp[31:16];
        end
        else
        begin
            stage_next     = olmss_pkg::STAGE_HOLD;
            iq_cmd_next    = run_current_reg;
            phase_acc_next = phase_hold;
            angle_next     = phase_hold[31:16];
        end
        tick_count_next = (tick_cur == olmss_pkg::TICK_MAX) ? tick_cur : (tick_cur + 16'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_end_reg      <= olmss_pkg::IDLE_END_RST;
            align_end_reg     <= olmss_pkg::ALIGN_END_RST;
            ramp_end_reg      <= olmss_pkg::RAMP_END_RST;
            align_current_reg <= olmss_pkg::ALIGN_CURRENT_RST;
            run_current_reg   <= olmss_pkg::RUN_CURRENT_RST;
            ramp_step_reg     <= olmss_pkg::RAMP_STEP_RST;
            hold_step_reg     <= olmss_pkg::HOLD_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                olmss_pkg::REG_IDLE_END:      idle_end_reg      <= cfg_wdata[15:0];
                olmss_pkg::REG_ALIGN_END:     align_end_reg     <= cfg_wdata[15:0];
                olmss_pkg::REG_RAMP_END:      ramp_end_reg      <= cfg_wdata[15:0];
                olmss_pkg::REG_ALIGN_CURRENT: align_current_reg <= cfg_wdata[14:0];
                olmss_pkg::REG_RUN_CURRENT:   run_current_reg   <= cfg_wdata[14:0];
                olmss_pkg::REG_RAMP_STEP:     ramp_step_reg     <= cfg_wdata[23:0];
                olmss_pkg::REG_HOLD_STEP:     hold_step_reg     <= cfg_wdata[31:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 16'd0;
            ramp_speed_reg <= 32'd0;
            phase_acc_reg  <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                tick_count_reg <= tick_count_next;
                ramp_speed_reg <= ramp_speed_next;
                phase_acc_reg  <= phase_acc_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            iq_cmd_reg <= iq_cmd_next;
            angle_reg  <= angle_next;
            stage_reg  <= stage_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty output register");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (stage_reg == olmss_pkg::STAGE_IDLE)
        |-> (iq_cmd == 15'd0) && (angle == 16'd0))
        else $error("idle item with nonzero current or angle");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && restart |=> (tick_count_reg == 16'd1))
        else $error("restart did not restart tick counter");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !restart && (tick_count_reg == olmss_pkg::TICK_MAX)
        |=> (tick_count_reg == olmss_pkg::TICK_MAX))
        else $error("tick counter wrapped");

    a_phase_still_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !restart && ((tick_count_reg < idle_end_reg) || (tick_count_reg < align_end_reg))
        |=> $stable(phase_acc_reg) && $stable(ramp_speed_reg))
        else $error("phase or speed moved during idle or align");
`endif

endmodule
